// File: rtl/tli_pkg.sv
// Shared types and constants for the table linear interpolator.
package tli_pkg;

   localparam int MaxPoints  = 64;
   localparam int IndexWidth = 6;
   localparam int DataWidth  = 16;
   localparam int CountWidth = 7;
   localparam int TolWidth   = 15;
   localparam int DiffWidth  = DataWidth + 1;      // x differences
   localparam int ProdWidth  = DataWidth + DiffWidth;
   localparam int AccWidth   = ProdWidth + 1;      // sum of two products
   localparam int MagWidth   = AccWidth - 1;       // numerator magnitude
   localparam int DivSteps   = MagWidth;
   localparam int StepWidth  = 6;

   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_QUERY = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      STAT_OK         = 2'd0,
      STAT_ABOVE      = 2'd1,
      STAT_BELOW      = 2'd2,
      STAT_ZERO_WIDTH = 2'd3
   } status_type;

   typedef enum logic {
      CSR_POINT_COUNT    = 1'b0,
      CSR_EDGE_TOLERANCE = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_FETCH,
      S_MUL_A,
      S_MUL_B,
      S_DIV_LOAD,
      S_DIV,
      S_DONE
   } state_type;

   typedef enum logic [2:0] {
      AOP_IDLE,
      AOP_MUL_A,
      AOP_MUL_B,
      AOP_DIV_LOAD,
      AOP_DIV_STEP
   } arith_op_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] x_lo;
      logic signed [DataWidth-1:0] y_lo;
      logic signed [DataWidth-1:0] x_hi;
      logic signed [DataWidth-1:0] y_hi;
      logic signed [DataWidth-1:0] q;
   } segment_type;

   typedef struct packed {
      logic                        done;
      logic                        zero_width;
      logic signed [DataWidth-1:0] y;
   } arith_res_type;

endpackage

// File: rtl/tli_table.sv
// Breakpoint store: one write port, one registered read port.
module tli_table (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [tli_pkg::IndexWidth-1:0]        wr_addr,
   input  logic [2*tli_pkg::DataWidth-1:0]       wr_data,   // {y, x}
   input  logic [tli_pkg::IndexWidth-1:0]        rd_addr,
   output logic [2*tli_pkg::DataWidth-1:0]       rd_data    // {y, x}
);

   logic [2*tli_pkg::DataWidth-1:0] mem [tli_pkg::MaxPoints];
   logic [2*tli_pkg::DataWidth-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/tli_arith.sv
// Shared multiply-accumulate and restoring divider with output saturation.
module tli_arith (
   input  logic                   clock,
   input  logic                   reset,
   input  tli_pkg::arith_op_type  op,
   input  tli_pkg::segment_type   seg,
   output tli_pkg::arith_res_type res
);

   localparam int DW = tli_pkg::DataWidth;

   logic signed [tli_pkg::DiffWidth-1:0] diff_hq;
   logic signed [tli_pkg::DiffWidth-1:0] diff_ql;
   logic signed [tli_pkg::DiffWidth-1:0] width;
   logic signed [DW-1:0]                 mul_a;
   logic signed [tli_pkg::DiffWidth-1:0] mul_b;
   logic signed [tli_pkg::ProdWidth-1:0] prod;
   logic signed [tli_pkg::AccWidth-1:0]  prod_ext;
   logic signed [tli_pkg::AccWidth-1:0]  acc_neg;
   logic [tli_pkg::DiffWidth-1:0]        width_neg;
   logic [DW:0]                          rem_sh;
   logic                                 rem_ge;

   logic signed [tli_pkg::AccWidth-1:0]  acc_ff, acc_in;
   logic [tli_pkg::MagWidth-1:0]         quo_ff, quo_in;
   logic [DW-1:0]                        rem_ff, rem_in;
   logic [DW-1:0]                        den_ff, den_in;
   logic                                 neg_ff, neg_in;
   logic [tli_pkg::StepWidth-1:0]        cnt_ff, cnt_in;

   assign diff_hq = {seg.x_hi[DW-1], seg.x_hi} - {seg.q[DW-1], seg.q};
   assign diff_ql = {seg.q[DW-1], seg.q} - {seg.x_lo[DW-1], seg.x_lo};
   assign width   = {seg.x_hi[DW-1], seg.x_hi} - {seg.x_lo[DW-1], seg.x_lo};

   // one multiplier, operands steered by the step
   assign mul_a    = (op == tli_pkg::AOP_MUL_B) ? seg.y_hi : seg.y_lo;
   assign mul_b    = (op == tli_pkg::AOP_MUL_B) ? diff_ql : diff_hq;
   assign prod     = mul_a * mul_b;
   assign prod_ext = {prod[tli_pkg::ProdWidth-1], prod};
   assign acc_neg  = -acc_ff;
   assign width_neg = -width;

   assign rem_sh = {rem_ff, quo_ff[tli_pkg::MagWidth-1]};
   assign rem_ge = (rem_sh >= {1'b0, den_ff});

   always_comb begin
      acc_in = acc_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      case (op)
         tli_pkg::AOP_MUL_A: begin
            acc_in = prod_ext;
         end
         tli_pkg::AOP_MUL_B: begin
            acc_in = acc_ff + prod_ext;
         end
         tli_pkg::AOP_DIV_LOAD: begin
            quo_in = acc_ff[tli_pkg::AccWidth-1] ? acc_neg[tli_pkg::MagWidth-1:0]
                                                 : acc_ff[tli_pkg::MagWidth-1:0];
            neg_in = acc_ff[tli_pkg::AccWidth-1] ^ width[tli_pkg::DiffWidth-1];
            den_in = width[tli_pkg::DiffWidth-1] ? width_neg[DW-1:0] : width[DW-1:0];
            rem_in = '0;
            cnt_in = '0;
         end
         tli_pkg::AOP_DIV_STEP: begin
            rem_in = rem_ge ? DW'(rem_sh - {1'b0, den_ff}) : rem_sh[DW-1:0];
            quo_in = {quo_ff[tli_pkg::MagWidth-2:0], rem_ge};
            cnt_in = cnt_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      acc_ff <= acc_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   // saturate the truncated quotient to the signed output range
   always_comb begin
      res.done       = (cnt_ff == tli_pkg::StepWidth'(tli_pkg::DivSteps));
      res.zero_width = (width == '0);
      if (neg_ff) begin
         if (quo_ff >= (tli_pkg::MagWidth'(1) << (DW - 1))) begin
            res.y = {1'b1, {(DW-1){1'b0}}};
         end else begin
            res.y = -$signed(quo_ff[DW-1:0]);
         end
      end else begin
         if (quo_ff > tli_pkg::MagWidth'({(DW-1){1'b1}})) begin
            res.y = {1'b0, {(DW-1){1'b1}}};
         end else begin
            res.y = $signed(quo_ff[DW-1:0]);
         end
      end
   end

endmodule

// File: rtl/table_linear_interpolator_unit.sv
// Top level: piecewise linear interpolation table with query sequencer.
//
//   channel | dir | tdata / payload                        | tuser
//   --------+-----+----------------------------------------+---------------
//   req_    | in  | [5:0] point_index [21:6] point_x        | command
//           |     | [37:22] point_y, [39:38] zero          |
//   rsp_    | out | [15:0] interp_y                        | [1:0] status
//   csr_    | in  | csr_index 0 point_count, 1 edge_tol.   | -
//
// A load transfer gives no result. A query runs the table search (one breakpoint
// read per cycle from the single read port, compared from its registered output),
// the multiply steps, the divider load and the divider steps, then the result state;
// the search ends early on a hit, and out-of-range or zero-width queries skip the divider.
// Synchronous active-high reset clears the sequencer, output valid and configuration
// registers; data registers and the table are not cleared. The result sits in an output
// register, so a stalled rsp_ side only holds the next query in its result cycle.
module table_linear_interpolator_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [39:0]                            req_tdata,  // index, x, y, pad
   input  logic                                   req_tuser,  // command
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [15:0]                            rsp_tdata,  // interp_y
   output logic [1:0]                             rsp_tuser,  // status
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic                                   csr_index,
   input  logic [tli_pkg::TolWidth-1:0]           csr_data
);

   localparam int DW = tli_pkg::DataWidth;
   localparam int IW = tli_pkg::IndexWidth;

   tli_pkg::state_type     state_ff, state_in;
   tli_pkg::arith_op_type  aop;
   tli_pkg::segment_type   seg;
   tli_pkg::arith_res_type ares;
   tli_pkg::status_type    status_ff, status_in;

   logic [tli_pkg::CountWidth-1:0] point_count_ff;
   logic [tli_pkg::TolWidth-1:0]   edge_tol_ff;

   logic signed [DW-1:0] q_ff, q_in;
   logic signed [DW-1:0] x_lo_ff, x_lo_in, y_lo_ff, y_lo_in;
   logic signed [DW-1:0] x_hi_ff, x_hi_in, y_hi_ff, y_hi_in;
   logic [tli_pkg::CountWidth-1:0] issue_ff, issue_in;
   logic [IW-1:0]                  cidx_ff, cidx_in;
   logic                           pend_ff, pend_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]  rsp_y_ff, rsp_y_in;
   logic [1:0]     rsp_stat_ff, rsp_stat_in;

   logic                  req_xfer, load_xfer, query_xfer;
   logic [2*DW-1:0]       rd_data;
   logic signed [DW-1:0]  rd_x, rd_y;
   logic                  hit, in_tol, last_cmp, rsp_load;
   logic [DW:0]           x_gap;
   logic [tli_pkg::CountWidth-1:0] n_used;
   logic [IW-1:0]         n_last;

   assign req_tready = (state_ff == tli_pkg::S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign load_xfer  = req_xfer && (req_tuser == tli_pkg::CMD_LOAD);
   assign query_xfer = req_xfer && (req_tuser == tli_pkg::CMD_QUERY);

   // configuration, always taken; the user must write it only while idle, the block does not enforce this
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= tli_pkg::CountWidth'(2);
         edge_tol_ff    <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tli_pkg::CSR_POINT_COUNT:    point_count_ff <= csr_data[tli_pkg::CountWidth-1:0];
            tli_pkg::CSR_EDGE_TOLERANCE: edge_tol_ff    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // breakpoints in use, clamped to 2..MaxPoints
   always_comb begin
      if (point_count_ff < tli_pkg::CountWidth'(2)) begin
         n_used = tli_pkg::CountWidth'(2);
      end else if (point_count_ff > tli_pkg::CountWidth'(tli_pkg::MaxPoints)) begin
         n_used = tli_pkg::CountWidth'(tli_pkg::MaxPoints);
      end else begin
         n_used = point_count_ff;
      end
   end
   assign n_last = IW'(n_used - 1'b1);

   tli_table u_table (
      .clock   (clock),
      .wr_en   (load_xfer),
      .wr_addr (req_tdata[IW-1:0]),
      .wr_data ({req_tdata[37:22], req_tdata[21:6]}),
      .rd_addr (issue_ff[IW-1:0]),
      .rd_data (rd_data)
   );

   assign rd_x = rd_data[DW-1:0];
   assign rd_y = rd_data[2*DW-1:DW];

   // search compare on the entry read last cycle (index cidx_ff)
   assign hit      = (rd_x >= q_ff);
   assign x_gap    = {rd_x[DW-1], rd_x} - {q_ff[DW-1], q_ff};
   assign in_tol   = (x_gap <= (DW+1)'(edge_tol_ff));
   assign last_cmp = (cidx_ff == n_last);

   assign seg.x_lo = x_lo_ff;
   assign seg.y_lo = y_lo_ff;
   assign seg.x_hi = x_hi_ff;
   assign seg.y_hi = y_hi_ff;
   assign seg.q    = q_ff;

   tli_arith u_arith (
      .clock (clock),
      .reset (reset),
      .op    (aop),
      .seg   (seg),
      .res   (ares)
   );

   assign rsp_load = (!rsp_valid_ff || rsp_tready);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tli_pkg::S_IDLE: begin
            if (query_xfer) state_in = tli_pkg::S_SEARCH;
         end
         tli_pkg::S_SEARCH: begin
            if (pend_ff) begin
               if (hit) begin
                  if (cidx_ff == '0) begin
                     state_in = in_tol ? tli_pkg::S_FETCH : tli_pkg::S_DONE;
                  end else begin
                     state_in = tli_pkg::S_MUL_A;
                  end
               end else if (last_cmp) begin
                  state_in = tli_pkg::S_DONE;
               end
            end
         end
         tli_pkg::S_FETCH:    state_in = tli_pkg::S_MUL_A;
         tli_pkg::S_MUL_A:    state_in = ares.zero_width ? tli_pkg::S_DONE : tli_pkg::S_MUL_B;
         tli_pkg::S_MUL_B:    state_in = tli_pkg::S_DIV_LOAD;
         tli_pkg::S_DIV_LOAD: state_in = tli_pkg::S_DIV;
         tli_pkg::S_DIV: begin
            if (ares.done) state_in = tli_pkg::S_DONE;
         end
         tli_pkg::S_DONE: begin
            if (rsp_load) state_in = tli_pkg::S_IDLE;
         end
         default: state_in = tli_pkg::S_IDLE;
      endcase
   end

   // arithmetic unit step per state
   always_comb begin
      unique case (state_ff)
         tli_pkg::S_MUL_A:    aop = tli_pkg::AOP_MUL_A;
         tli_pkg::S_MUL_B:    aop = tli_pkg::AOP_MUL_B;
         tli_pkg::S_DIV_LOAD: aop = tli_pkg::AOP_DIV_LOAD;
         tli_pkg::S_DIV:      aop = ares.done ? tli_pkg::AOP_IDLE : tli_pkg::AOP_DIV_STEP;
         default:             aop = tli_pkg::AOP_IDLE;
      endcase
   end

   // search and segment registers
   always_comb begin
      q_in      = q_ff;
      x_lo_in   = x_lo_ff;
      y_lo_in   = y_lo_ff;
      x_hi_in   = x_hi_ff;
      y_hi_in   = y_hi_ff;
      issue_in  = issue_ff;
      cidx_in   = cidx_ff;
      pend_in   = 1'b0;
      status_in = status_ff;
      unique case (state_ff)
         tli_pkg::S_IDLE: begin
            q_in      = req_tdata[21:6];
            issue_in  = '0;
            status_in = tli_pkg::STAT_OK;
         end
         tli_pkg::S_SEARCH: begin
            issue_in = issue_ff + 1'b1;
            cidx_in  = issue_ff[IW-1:0];
            pend_in  = 1'b1;
            if (pend_ff) begin
               if (hit && (cidx_ff != '0)) begin
                  x_hi_in = rd_x;
                  y_hi_in = rd_y;
               end else begin
                  // a miss becomes the low end; so does the first entry
                  x_lo_in = rd_x;
                  y_lo_in = rd_y;
               end
               if (hit && (cidx_ff == '0) && !in_tol) begin
                  status_in = tli_pkg::STAT_BELOW;
               end else if (!hit && last_cmp) begin
                  status_in = tli_pkg::STAT_ABOVE;
               end
            end
         end
         tli_pkg::S_FETCH: begin
            // entry 1 was read while entry 0 was compared
            x_hi_in = rd_x;
            y_hi_in = rd_y;
         end
         tli_pkg::S_MUL_A: begin
            if (ares.zero_width) status_in = tli_pkg::STAT_ZERO_WIDTH;
         end
         default: begin
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_y_in     = rsp_y_ff;
      rsp_stat_in  = rsp_stat_ff;
      if ((state_ff == tli_pkg::S_DONE) && rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_stat_in  = status_ff;
         rsp_y_in     = (status_ff == tli_pkg::STAT_OK) ? ares.y : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tli_pkg::S_IDLE;
         pend_ff      <= 1'b0;
         issue_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         status_ff    <= tli_pkg::STAT_OK;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         issue_ff     <= issue_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
      end
      q_ff        <= q_in;
      x_lo_ff     <= x_lo_in;
      y_lo_ff     <= y_lo_in;
      x_hi_ff     <= x_hi_in;
      y_hi_ff     <= y_hi_in;
      cidx_ff     <= cidx_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_y_ff;
   assign rsp_tuser  = rsp_stat_ff;

`ifndef SYNTHESIS
   // a query transfer always starts the search
   a_query_starts: assert property (@(posedge clock) disable iff (reset)
      query_xfer |=> (state_ff == tli_pkg::S_SEARCH))
      else $error("query transfer did not start search");

   // zero-width segments never reach the divider
   a_no_zero_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tli_pkg::S_DIV_LOAD) |-> !ares.zero_width)
      else $error("divider loaded with zero-width segment");

   // error results carry a zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != tli_pkg::STAT_OK)) |-> (rsp_tdata == '0))
      else $error("error result with nonzero value");

   // a load never produces a result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (load_xfer && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("load produced a result");
`endif

endmodule

// File: test/table_linear_interpolator_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for the table linear interpolator: directed and random stimulus checked by a predictor.
module table_linear_interpolator_unit_tb;
   import tli_pkg::*;

   // Watchdog: the slowest legal quiet stretch is a receiver hold-off of HoldCycles, plus one
   // query, plus the longest random gaps on both sides; the limit is several times that sum.
   localparam int IdleLimit    = 5000;
   localparam int HoldCycles   = 600;
   localparam int SettleCycles = 120;  // longest query latency with margin
   localparam int ReportLimit  = 10;

   typedef struct packed {
      logic signed [DataWidth-1:0] query_x;
      logic signed [DataWidth-1:0] interp_y;
      status_type                  status;
   } interp_result_t;

   // Mirrors the breakpoint table and registers and holds the results still owed.
   class interp_scoreboard;
      bit signed [DataWidth-1:0] bp_x [MaxPoints];
      bit signed [DataWidth-1:0] bp_y [MaxPoints];
      bit [CountWidth-1:0]       point_count;
      bit [TolWidth-1:0]         edge_tolerance;
      interp_result_t            awaited [$];
      int                        errors;

      function new();
         point_count    = 2;
         edge_tolerance = 0;
         errors         = 0;
         foreach (bp_x[k]) begin
            bp_x[k] = 0;
            bp_y[k] = 0;
         end
      endfunction

      // Count register clamped to the legal table size.
      function int points_in_use();
         if (point_count < 2) return 2;
         if (point_count > MaxPoints) return MaxPoints;
         return point_count;
      endfunction

      function void set_reg(csr_index_type idx, bit [TolWidth-1:0] value);
         if (idx == CSR_POINT_COUNT) point_count = value[CountWidth-1:0];
         else edge_tolerance = value;
      endfunction

      function interp_result_t interpolate(logic signed [DataWidth-1:0] q);
         interp_result_t r;
         int             n, i;
         longint         qv, x_lo, x_hi, y_lo, y_hi, width, num, quo;
         qv         = q;
         r.query_x  = q;
         r.interp_y = '0;
         r.status   = STAT_OK;
         n          = points_in_use();
         i          = 0;
         while (i < n && longint'(bp_x[i]) < qv) i++;
         if (i == n) begin
            r.status = STAT_ABOVE;
         end else begin
            // Below the first x: extrapolate from the first segment within tolerance.
            if (i == 0) begin
               if (longint'(bp_x[0]) - qv <= longint'(edge_tolerance)) i = 1;
               else r.status = STAT_BELOW;
            end
            if (r.status == STAT_OK) begin
               x_lo  = bp_x[i-1];
               x_hi  = bp_x[i];
               y_lo  = bp_y[i-1];
               y_hi  = bp_y[i];
               width = x_hi - x_lo;
               if (width == 0) begin
                  r.status = STAT_ZERO_WIDTH;
               end else begin
                  num = y_lo * (x_hi - qv) + y_hi * (qv - x_lo);
                  quo = num / width;  // truncates toward zero
                  if (quo > 32767) quo = 32767;
                  else if (quo < -32768) quo = -32768;
                  r.interp_y = quo[DataWidth-1:0];
               end
            end
         end
         return r;
      endfunction

      function void note_request(command_type cmd, bit [IndexWidth-1:0] slot,
                                 bit signed [DataWidth-1:0] x, bit signed [DataWidth-1:0] y);
         if (cmd == CMD_LOAD) begin
            bp_x[slot] = x;
            bp_y[slot] = y;
         end else begin
            awaited.push_back(interpolate(x));
         end
      endfunction

      function void check_response(logic [DataWidth-1:0] y, logic [1:0] st);
         interp_result_t want;
         if (awaited.size() == 0) begin
            errors++;
            if (errors <= ReportLimit)
               $display("unexpected result: y=%0d status=%0d", $signed(y), st);
            return;
         end
         want = awaited.pop_front();
         if (y !== want.interp_y || st !== want.status) begin
            errors++;
            if (errors <= ReportLimit)
               $display("mismatch for q=%0d: expected y=%0d status=%0d, got y=%0d status=%0d",
                        want.query_x, want.interp_y, want.status, $signed(y), st);
         end
      endfunction
   endclass

   logic                clock        = 1'b0;
   logic                reset        = 1'b1;
   logic                req_tvalid   = 1'b0;
   logic                req_tready;
   logic [39:0]         req_tdata    = '0;    // [5:0] point_index, [21:6] point_x, [37:22] point_y
   logic                req_tuser    = 1'b0;  // command
   logic                rsp_tvalid;
   logic                rsp_tready   = 1'b0;
   logic [15:0]         rsp_tdata;            // interp_y
   logic [1:0]          rsp_tuser;            // status
   logic                csr_valid    = 1'b0;
   logic                csr_ready;
   logic                csr_index    = 1'b0;
   logic [TolWidth-1:0] csr_data     = '0;

   bit                  idling       = 1'b1;  // random gaps on both sides
   bit                  hold_request = 1'b0;  // asks the receiver for a long hold-off

   interp_scoreboard sb;

   table_linear_interpolator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Both monitors sample at the rising edge; the inputs only move at the falling edge.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_request(command_type'(req_tuser), req_tdata[5:0], req_tdata[21:6],
                         req_tdata[37:22]);
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata, rsp_tuser);
   end

   // Mostly short gaps, now and then a long one.
   function automatic int gap_len();
      int r;
      r = $urandom_range(99);
      if (r < 75) return 0;
      if (r < 95) return $urandom_range(4, 1);
      return $urandom_range(60, 20);
   endfunction

   function automatic bit [15:0] clip16(int v);
      if (v > 32767) return 16'h7FFF;
      if (v < -32768) return 16'h8000;
      return v[15:0];
   endfunction

   function automatic bit [15:0] pick_y();
      if ($urandom_range(1)) return 16'($urandom);
      return clip16(int'($urandom_range(4095)) - 2048);
   endfunction

   // Query x aimed at breakpoints, segment interiors, the tolerance edge and the top end.
   function automatic bit [15:0] pick_query();
      int n, k, lo, hi, r;
      n = sb.points_in_use();
      r = $urandom_range(99);
      if (r < 25) return sb.bp_x[$urandom_range(n - 1)];
      if (r < 55) begin
         k  = $urandom_range(n - 2);
         lo = sb.bp_x[k];
         hi = sb.bp_x[k+1];
         if (lo > hi) begin
            r  = lo;
            lo = hi;
            hi = r;
         end
         return clip16(lo + int'($urandom_range(hi - lo)));
      end
      if (r < 70)
         return clip16(int'(sb.bp_x[0]) - int'(sb.edge_tolerance) + int'($urandom_range(4)) - 2);
      if (r < 80) return clip16(int'(sb.bp_x[n-1]) + int'($urandom_range(3)));
      return 16'($urandom);
   endfunction

   // Called at a falling edge; leaves tvalid high so back-to-back transfers stay possible.
   task automatic send_request(command_type cmd, bit [5:0] slot, bit [15:0] x, bit [15:0] y);
      int gap;
      gap = idling ? gap_len() : 0;
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  = cmd;
      req_tdata  = {2'b00, y, x, slot};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, bit [TolWidth-1:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Loads give no result, so a settle time follows the last owed result.
   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (sb.awaited.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   // Fills slots 0..n-1 so that no query can read an unwritten entry. Mostly ascending,
   // narrow steps give many zero-width segments, a few tables are unordered.
   task automatic load_table(int n);
      int  step_max, x, k;
      bit  messy;
      messy    = ($urandom_range(9) == 0);
      step_max = $urandom_range(1) ? 3 : 65535 / (n - 1);
      x        = -32768 + int'($urandom_range(65535 - step_max * (n - 1)));
      for (k = 0; k < n; k++) begin
         send_request(CMD_LOAD, k[5:0], messy ? 16'($urandom) : x[15:0], pick_y());
         x += int'($urandom_range(step_max));
      end
   endtask

   task automatic run_phase(bit [CountWidth-1:0] count, bit [TolWidth-1:0] tol, int items,
                            bit calm, bit hold_out, bit drain_mid);
      int k;
      wait_drained();
      write_csr(CSR_POINT_COUNT, TolWidth'(count));
      write_csr(CSR_EDGE_TOLERANCE, tol);
      idling = !calm;
      load_table(sb.points_in_use());
      // Receiver stalls long while queries keep coming: output and input both back up.
      if (hold_out) hold_request = 1'b1;
      for (k = 0; k < items; k++) begin
         if (drain_mid && k == items / 2) wait_drained();
         if ($urandom_range(9) == 0)
            send_request(CMD_LOAD, 6'($urandom), 16'($urandom), 16'($urandom));
         else
            send_request(CMD_QUERY, 6'($urandom), pick_query(), 16'($urandom));
      end
      idling = 1'b1;
   endtask

   initial begin : receiver
      int stall;
      stall = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall        = HoldCycles;
         end else if (stall == 0 && idling) begin
            stall = gap_len();
         end
         if (stall > 0) begin
            rsp_tready = 1'b0;
            stall--;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < IdleLimit) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("table_linear_interpolator_unit_tb NOT OK");
      $finish;
   end

   initial begin : stimulus
      sb = new();
      repeat (2) @(negedge clock);
      reset = 1'b0;

      // Reset settings: two points, zero tolerance.
      send_request(CMD_LOAD, 6'd0, 16'hFF00, 16'h0100);    // (-1.0, 1.0)
      send_request(CMD_LOAD, 6'd1, 16'h0200, 16'hFC00);    // (2.0, -4.0)
      send_request(CMD_LOAD, 6'd63, 16'h7FFF, 16'h8000);   // top slot, never searched here
      send_request(CMD_QUERY, 6'd0, 16'hFF00, 16'h0000);   // equal to first x
      send_request(CMD_QUERY, 6'd0, 16'h0200, 16'h0000);   // equal to last x
      send_request(CMD_QUERY, 6'd0, 16'h0080, 16'h0000);   // inside the segment
      send_request(CMD_QUERY, 6'd0, 16'h0201, 16'h0000);   // just above range
      send_request(CMD_QUERY, 6'd0, 16'hFEFF, 16'h0000);   // just below, no tolerance
      send_request(CMD_QUERY, 6'd0, 16'h8000, 16'h0000);   // most negative query
      send_request(CMD_QUERY, 6'd0, 16'h7FFF, 16'h0000);   // most positive query

      // Full tolerance: extrapolation, saturation, zero width, descending table.
      wait_drained();
      write_csr(CSR_EDGE_TOLERANCE, 15'h7FFF);
      send_request(CMD_LOAD, 6'd0, 16'h0000, 16'h0000);
      send_request(CMD_LOAD, 6'd1, 16'h0001, 16'h7FFF);
      send_request(CMD_QUERY, 6'd0, 16'h8001, 16'h0000);   // steep extrapolation, low clamp
      send_request(CMD_QUERY, 6'd0, 16'h8000, 16'h0000);   // one past tolerance
      send_request(CMD_LOAD, 6'd1, 16'h0001, 16'h8000);
      send_request(CMD_QUERY, 6'd0, 16'h8001, 16'h0000);   // high clamp
      send_request(CMD_LOAD, 6'd1, 16'h0000, 16'h0005);
      send_request(CMD_QUERY, 6'd0, 16'h0000, 16'h0000);   // zero-width segment
      send_request(CMD_LOAD, 6'd0, 16'h7FFF, 16'h7FFF);
      send_request(CMD_LOAD, 6'd1, 16'h8000, 16'h8000);
      send_request(CMD_QUERY, 6'd0, 16'h0000, 16'h0000);   // negative segment width

      // Random phases: count, tolerance, items, calm, hold-off, mid-phase drain.
      run_phase(7'd2,   15'd0,     220, 1'b0, 1'b0, 1'b0);
      run_phase(7'd64,  15'h7FFF,  200, 1'b0, 1'b0, 1'b0);
      run_phase(7'd8,   15'($urandom), 220, 1'b1, 1'b0, 1'b0);
      run_phase(7'd0,   15'($urandom), 220, 1'b0, 1'b1, 1'b0);
      run_phase(7'd127, 15'($urandom_range(512)), 200, 1'b0, 1'b0, 1'b1);
      run_phase(7'd1,   15'h7FFF,  220, 1'b0, 1'b0, 1'b0);
      run_phase(7'd65,  15'd0,     200, 1'b0, 1'b0, 1'b0);
      run_phase(7'($urandom_range(16, 2)), 15'($urandom), 250, 1'b0, 1'b0, 1'b0);
      run_phase(7'($urandom_range(64, 2)), 15'($urandom), 250, 1'b0, 1'b0, 1'b0);

      wait_drained();
      if (sb.errors == 0 && sb.awaited.size() == 0)
         $display("table_linear_interpolator_unit_tb OK");
      else
         $display("table_linear_interpolator_unit_tb NOT OK");
      $finish;
   end

endmodule
